FILE: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check, disabled while reset is held.
`define IIRL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Signal must hold its value in the cycle after the condition.
`define IIRL_ASSERT_HOLD(lbl, clk, rst_n, cond, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error(msg);

`endif

FILE: sv/iirl_pkg.sv
// Types, codes and constants of the indexed insert/remove list.
package iirl_pkg;

    localparam int unsigned DEF_CAPACITY = 64;
    localparam int unsigned IDX_W        = 7;
    localparam int unsigned WORD_W       = 32;
    localparam int unsigned LEN_W        = 7;

    typedef enum logic [2:0] {
        REQ_READ   = 3'd0,
        REQ_WRITE  = 3'd1,
        REQ_INSERT = 3'd2,
        REQ_REMOVE = 3'd3,
        REQ_FILL   = 3'd4
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_req_type                req_type;
        logic [IDX_W-1:0]         index;
        logic signed [WORD_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [WORD_W-1:0] read_value;
        t_status                  status;
        logic [LEN_W-1:0]         length;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MOVE,
        S_PUT,
        S_FILL,
        S_DONE
    } t_state;

endpackage

FILE: sv/iirl_mem.sv
// Element store: one write port, one read port, registered read data.
module iirl_mem
    import iirl_pkg::*;
#(
    parameter int unsigned CAPACITY = DEF_CAPACITY,
    localparam int unsigned AW      = $clog2(CAPACITY)
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [AW-1:0]            i_rd_addr,
    output logic signed [WORD_W-1:0] o_rd_data,
    input  logic                     i_wr_en,
    input  logic [AW-1:0]            i_wr_addr,
    input  logic signed [WORD_W-1:0] i_wr_data
);

    logic signed [WORD_W-1:0] r_mem [CAPACITY];
    logic signed [WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/iirl_ctrl.sv
// Request sequencer: range checks, shift walks and fill sweep over the store.
module iirl_ctrl
    import iirl_pkg::*;
#(
    parameter int unsigned CAPACITY = DEF_CAPACITY,
    localparam int unsigned AW      = $clog2(CAPACITY)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  t_in_item                 i_req,
    output logic                     o_busy,
    output logic                     o_done,
    output t_out_item                o_rsp,
    output logic                     o_rd_en,
    output logic [AW-1:0]            o_rd_addr,
    input  logic signed [WORD_W-1:0] i_rd_data,
    output logic                     o_wr_en,
    output logic [AW-1:0]            o_wr_addr,
    output logic signed [WORD_W-1:0] o_wr_data
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned XW = (CW > IDX_W) ? CW : IDX_W;

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [AW-1:0]            r_ptr, n_ptr;
    logic [AW-1:0]            r_end, n_end;
    logic [AW-1:0]            r_pos, n_pos;
    logic                     r_ins, n_ins;
    logic signed [WORD_W-1:0] r_word, n_word;
    logic signed [WORD_W-1:0] r_rdval, n_rdval;
    t_status                  r_status, n_status;

    logic [XW-1:0] pos_x, cnt_x;
    logic [AW-1:0] pos_a, pos_a_p1, cnt_a_m1;
    logic          pos_lt, pos_le, is_full, rm_last, ins_tail, at_end;

    assign pos_x    = XW'(i_req.index);
    assign cnt_x    = XW'(r_count);
    assign pos_a    = pos_x[AW-1:0];
    assign pos_a_p1 = AW'(pos_x + XW'(1));
    assign cnt_a_m1 = AW'(cnt_x - XW'(1));
    assign pos_lt   = pos_x < cnt_x;
    assign pos_le   = pos_x <= cnt_x;
    assign is_full  = cnt_x == XW'(CAPACITY);
    assign rm_last  = XW'(pos_x + XW'(1)) == cnt_x;
    assign ins_tail = pos_x == cnt_x;
    assign at_end   = r_ptr == r_end;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_req.req_type)
                        REQ_READ:   n_state = pos_lt ? S_READ : S_DONE;
                        REQ_INSERT: n_state = (pos_le && !is_full && !ins_tail) ? S_MOVE
                                                                                : S_DONE;
                        REQ_REMOVE: n_state = (pos_lt && !rm_last) ? S_MOVE : S_DONE;
                        REQ_FILL:   n_state = (cnt_x != '0) ? S_FILL : S_DONE;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_READ:  n_state = S_DONE;
            S_MOVE:  n_state = at_end ? (r_ins ? S_PUT : S_DONE) : S_MOVE;
            S_PUT:   n_state = S_DONE;
            S_FILL:  n_state = at_end ? S_DONE : S_FILL;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Memory port controls and completion
    always_comb begin
        o_rd_en   = 1'b0;
        o_rd_addr = r_ptr;
        o_wr_en   = 1'b0;
        o_wr_addr = r_ptr;
        o_wr_data = r_word;
        o_done    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_req.req_type)
                        REQ_READ: begin
                            o_rd_en   = pos_lt;
                            o_rd_addr = pos_a;
                        end
                        REQ_WRITE: begin
                            o_wr_en   = pos_lt;
                            o_wr_addr = pos_a;
                            o_wr_data = i_req.value;
                        end
                        REQ_INSERT: begin
                            if (pos_le && !is_full) begin
                                if (ins_tail) begin
                                    o_wr_en   = 1'b1;
                                    o_wr_addr = pos_a;
                                    o_wr_data = i_req.value;
                                end else begin
                                    o_rd_en   = 1'b1;
                                    o_rd_addr = cnt_a_m1;
                                end
                            end
                        end
                        REQ_REMOVE: begin
                            o_rd_en   = pos_lt && !rm_last;
                            o_rd_addr = pos_a_p1;
                        end
                        default: ;
                    endcase
                end
            end
            S_MOVE: begin
                // write the word read last cycle one place along, fetch the next
                o_wr_en   = 1'b1;
                o_wr_addr = r_ins ? r_ptr + AW'(1) : r_ptr - AW'(1);
                o_wr_data = i_rd_data;
                o_rd_en   = !at_end;
                o_rd_addr = r_ins ? r_ptr - AW'(1) : r_ptr + AW'(1);
            end
            S_PUT: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_pos;
            end
            S_FILL: begin
                o_wr_en = 1'b1;
            end
            S_DONE: begin
                o_done = 1'b1;
            end
            default: ;
        endcase
    end

    // Datapath next values
    always_comb begin
        n_count  = r_count;
        n_ptr    = r_ptr;
        n_end    = r_end;
        n_pos    = r_pos;
        n_ins    = r_ins;
        n_word   = r_word;
        n_rdval  = r_rdval;
        n_status = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_word   = i_req.value;
                    n_pos    = pos_a;
                    n_rdval  = '0;
                    n_ins    = i_req.req_type == REQ_INSERT;
                    n_status = ST_OK;
                    n_ptr    = '0;
                    n_end    = cnt_a_m1;
                    case (i_req.req_type)
                        REQ_READ, REQ_WRITE: begin
                            if (!pos_lt) n_status = ST_RANGE;
                        end
                        REQ_INSERT: begin
                            n_ptr = cnt_a_m1;
                            n_end = pos_a;
                            if (!pos_le) begin
                                n_status = ST_RANGE;
                            end else if (is_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_count = r_count + CW'(1);
                            end
                        end
                        REQ_REMOVE: begin
                            n_ptr = pos_a_p1;
                            if (pos_lt) begin
                                n_count = r_count - CW'(1);
                            end else begin
                                n_status = ST_RANGE;
                            end
                        end
                        REQ_FILL: ;
                        default:  n_status = ST_RANGE;
                    endcase
                end
            end
            S_READ: n_rdval = i_rd_data;
            S_MOVE: begin
                if (!at_end) n_ptr = r_ins ? r_ptr - AW'(1) : r_ptr + AW'(1);
            end
            S_FILL: begin
                if (!at_end) n_ptr = r_ptr + AW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_end    <= n_end;
        r_pos    <= n_pos;
        r_ins    <= n_ins;
        r_word   <= n_word;
        r_rdval  <= n_rdval;
        r_status <= n_status;
    end

    assign o_busy            = r_state != S_IDLE;
    assign o_rsp.read_value  = r_rdval;
    assign o_rsp.status      = r_status;
    assign o_rsp.length      = cnt_x[LEN_W-1:0];

endmodule

FILE: sv/indexed_insert_remove_list.sv
// Top level of the indexed insert/remove list: handshakes, sequencer and store.
//
//   Channel   Direction  Handshake                 Payload
//   request   in         i_in_valid / o_in_stall   i_in_data  (t_in_item)
//   result    out        o_out_valid / i_out_stall o_out_data (t_out_item)
//
// One request at a time. A read passes S_READ and S_DONE; write, rejected
// requests and tail insert/remove go straight to S_DONE. An insert at p moves
// length-p words down the store, then puts the new word; a remove moves
// length-p-1 up, one word per cycle on the single write port; fill writes each
// used word. Reset clears length, state and output valid only. A stalled result
// holds in the output register and blocks the next request until it is taken.
module indexed_insert_remove_list_core
    import iirl_pkg::*;
#(
    parameter int unsigned CAPACITY = DEF_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int unsigned AW = $clog2(CAPACITY);

    logic                     busy;
    logic                     done;
    logic                     accept;
    t_out_item                rsp;
    logic                     rd_en, wr_en;
    logic [AW-1:0]            rd_addr, wr_addr;
    logic signed [WORD_W-1:0] rd_data, wr_data;

    logic      r_out_valid;
    t_out_item r_out_data;

    // Take a transaction only when the sequencer is idle and the output
    // register is empty or being emptied in this cycle.
    assign o_in_stall = busy || (r_out_valid && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;

    iirl_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (accept),
        .i_req     (i_in_data),
        .o_busy    (busy),
        .o_done    (done),
        .o_rsp     (rsp),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data)
    );

    iirl_mem #(
        .CAPACITY (CAPACITY)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // Output register: load on completion, drop once the transaction is taken.
    // Completion can only land on an empty register, since acceptance needed it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out_data <= rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: sv/iirl_chk.sv
// Port-level checker for the list core and its bind.
`include "assert_macros.svh"

module iirl_chk
    import iirl_pkg::*;
#(
    parameter int unsigned CAPACITY = DEF_CAPACITY
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    logic in_acc;
    logic out_held;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_held = o_out_valid && i_out_stall;

    `IIRL_ASSERT_HOLD(a_out_hold, i_clk, i_rst_n, out_held, o_out_data, "stalled result changed")
    `IIRL_ASSERT(a_no_accept_held, i_clk, i_rst_n, out_held |-> o_in_stall, "accept while result held")
    `IIRL_ASSERT(a_accept_clears, i_clk, i_rst_n, in_acc |=> !o_out_valid, "result overlaps new request")
    `IIRL_ASSERT(a_full_len, i_clk, i_rst_n, (o_out_valid && o_out_data.status == ST_FULL) |-> (o_out_data.length == LEN_W'(CAPACITY)), "full status below capacity")
    `IIRL_ASSERT(a_rd_ok, i_clk, i_rst_n, (o_out_valid && o_out_data.read_value != '0) |-> (o_out_data.status == ST_OK), "read data on failed request")

endmodule

bind indexed_insert_remove_list_core iirl_chk #(
    .CAPACITY (CAPACITY)
) u_iirl_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

FILE: verif/tb.sv
// Self-checking testbench for the indexed insert/remove list core.
module tb;
    import iirl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LIST_CAP    = DEF_CAPACITY;
    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          DRAIN_WAIT  = 100;   // comfortably above the longest request
    localparam int          RANDOM_REQS = 2000;

    // Mix of requests for a stretch of the random part.
    typedef enum logic [1:0] {
        LIST_GROW,
        LIST_SHRINK,
        LIST_CHURN
    } t_list_mood;

    // Back-pressure pattern of the result side.
    typedef enum logic [1:0] {
        DRAIN_FREE,
        DRAIN_LIGHT,
        DRAIN_HEAVY
    } t_drain_mode;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    // Shadow of the list as the block should hold it after every accepted request.
    logic signed [WORD_W-1:0] shadow_words [LIST_CAP];
    int                       shadow_len = 0;

    // Length as the stimulus generator expects it once its queued requests are done.
    int        planned_len = 0;
    t_in_item  pending_reqs[$];
    t_out_item expected_results[$];

    int          err_count   = 0;
    int          cycle_count = 0;
    logic        req_taken   = 1'b0;
    int          burst_left  = 1;
    int          gap_left    = 0;
    t_drain_mode drain_mode  = DRAIN_FREE;
    int          drain_left  = 0;

    indexed_insert_remove_list_core #(
        .CAPACITY (LIST_CAP)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // Decide the status of a request against a given length. Shared by the
    // generator (to track the length) and the predictor.
    function automatic t_status judge_request(t_req_type kind, logic [IDX_W-1:0] pos, int len);
        case (kind)
            REQ_READ, REQ_WRITE, REQ_REMOVE: return (pos < len) ? ST_OK : ST_RANGE;
            REQ_INSERT: begin
                // position check comes before the full check
                if (pos > len) return ST_RANGE;
                if (len >= LIST_CAP) return ST_FULL;
                return ST_OK;
            end
            REQ_FILL: return ST_OK;
            default: return ST_RANGE;
        endcase
    endfunction

    // Apply one accepted request to the shadow list and return the result it should give.
    function automatic t_out_item apply_list_request(t_in_item req);
        t_out_item res;
        int        k;
        res = '0;
        res.status = judge_request(req.req_type, req.index, shadow_len);
        if (res.status == ST_OK) begin
            case (req.req_type)
                REQ_READ:  res.read_value = shadow_words[req.index];
                REQ_WRITE: shadow_words[req.index] = req.value;
                REQ_INSERT: begin
                    for (k = shadow_len; k > req.index; k--)
                        shadow_words[k] = shadow_words[k-1];
                    shadow_words[req.index] = req.value;
                    shadow_len++;
                end
                REQ_REMOVE: begin
                    for (k = req.index; k + 1 < shadow_len; k++)
                        shadow_words[k] = shadow_words[k+1];
                    shadow_len--;
                end
                REQ_FILL: begin
                    for (k = 0; k < shadow_len; k++)
                        shadow_words[k] = req.value;
                end
                default: ;
            endcase
        end
        res.length = LEN_W'(shadow_len);
        return res;
    endfunction

    // Queue a request and advance the planned length.
    task automatic queue_request(t_req_type kind, int pos, logic [WORD_W-1:0] word);
        t_in_item req;
        req.req_type = kind;
        req.index    = IDX_W'(pos);
        req.value    = word;
        if (judge_request(req.req_type, req.index, planned_len) == ST_OK) begin
            if (kind == REQ_INSERT) planned_len++;
            if (kind == REQ_REMOVE) planned_len--;
        end
        pending_reqs.push_back(req);
    endtask

    // Draw one random request, weighted by mood; mostly valid positions, some
    // on the boundary, some anywhere in the index field.
    task automatic queue_random_request(t_list_mood mood);
        int        r;
        int        hi;
        int        pos;
        t_req_type kind;
        logic [WORD_W-1:0] word;
        r = $urandom_range(0, 99);
        case (mood)
            LIST_GROW:
                kind = (r < 50) ? REQ_INSERT : (r < 63) ? REQ_READ : (r < 75) ? REQ_WRITE :
                       (r < 87) ? REQ_REMOVE : (r < 97) ? REQ_FILL : REQ_READ;
            LIST_SHRINK:
                kind = (r < 50) ? REQ_REMOVE : (r < 63) ? REQ_READ : (r < 75) ? REQ_WRITE :
                       (r < 87) ? REQ_INSERT : (r < 97) ? REQ_FILL : REQ_READ;
            default:
                kind = (r < 28) ? REQ_INSERT : (r < 54) ? REQ_REMOVE : (r < 74) ? REQ_READ :
                       (r < 89) ? REQ_WRITE : (r < 97) ? REQ_FILL : REQ_READ;
        endcase
        // a few unknown request codes
        if (r >= 97) kind = t_req_type'(3'($urandom_range(5, 7)));

        r  = $urandom_range(0, 99);
        hi = (kind == REQ_INSERT) ? planned_len : planned_len - 1;
        if (r < 80)
            pos = (hi < 0) ? 0 : $urandom_range(0, hi);
        else if (r < 90)
            pos = hi + 1;
        else
            pos = $urandom_range(0, 127);

        r = $urandom_range(0, 99);
        case (r % 8)
            0:       word = 32'h8000_0000;
            1:       word = 32'h7FFF_FFFF;
            2:       word = 32'hFFFF_FFFF;
            3:       word = 32'h0000_0000;
            default: word = $urandom;
        endcase
        if (r >= 15) word = $urandom;
        queue_request(kind, pos, word);
    endtask

    // Compare one delivered result with the oldest expectation.
    task automatic check_result(t_out_item got);
        t_out_item want;
        if (expected_results.size() == 0) begin
            $error("result with no request outstanding: read_value %0d status %0d length %0d",
                   got.read_value, got.status, got.length);
            err_count++;
            return;
        end
        want = expected_results.pop_front();
        if (got.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
            err_count++;
        end
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            err_count++;
        end
        if (got.length !== want.length) begin
            $error("length: expected %0d, got %0d", want.length, got.length);
            err_count++;
        end
    endtask

    // Monitor: sample both handshakes at the rising edge. Predict on request
    // acceptance first, so a result in the same edge always finds its entry.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else if (i_rst_n) begin
            req_taken <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall)
                expected_results.push_back(apply_list_request(i_in_data));
            if (o_out_valid && !i_out_stall)
                check_result(o_out_data);
        end
    end

    // Driver: change the request side at the falling edge. Hold the payload
    // while stalled; after a transaction take the next item unless a gap is due.
    // Bursts of random length alternate with gaps, some of them empty.
    always @(negedge i_clk) begin
        logic     nxt_valid;
        t_in_item nxt_data;
        nxt_valid = i_in_valid;
        nxt_data  = i_in_data;
        if (i_rst_n) begin
            if (req_taken) nxt_valid = 1'b0;
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_reqs.size() != 0) begin
                    nxt_data  = pending_reqs.pop_front();
                    nxt_valid = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
        i_in_valid <= nxt_valid;
        i_in_data  <= nxt_data;
    end

    // Receiver: stretches with no stall, light stalling and heavy stalling.
    always @(negedge i_clk) begin
        if (drain_left == 0) begin
            drain_mode <= t_drain_mode'($urandom_range(0, 2));
            drain_left <= $urandom_range(20, 150);
        end else begin
            drain_left <= drain_left - 1;
        end
        case (drain_mode)
            DRAIN_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            DRAIN_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
            default:     i_out_stall <= 1'b0;
        endcase
    end

    initial begin
        t_list_mood mood;
        int         mood_left;
        int         n;

        // Directed opening: empty-list cases, head/middle/tail inserts with
        // extreme words, reads at the edges, removes, unknown codes, then
        // empty the list again and remove from it once more.
        queue_request(REQ_READ,   0, 32'h0);
        queue_request(REQ_REMOVE, 0, 32'h0);
        queue_request(REQ_WRITE,  0, 32'h1);
        queue_request(REQ_FILL,   0, 32'hDEAD_BEEF);
        queue_request(REQ_INSERT, 1, 32'h2);
        queue_request(REQ_INSERT, 0, 32'h8000_0000);
        queue_request(REQ_INSERT, 1, 32'h7FFF_FFFF);
        queue_request(REQ_INSERT, 0, 32'hFFFF_FFFF);
        queue_request(REQ_INSERT, 1, 32'h0000_0000);
        queue_request(REQ_READ,   0, 32'h0);
        queue_request(REQ_READ,   3, 32'h0);
        queue_request(REQ_READ,   4, 32'h0);
        queue_request(REQ_READ,   127, 32'hFFFF_FFFF);
        queue_request(REQ_WRITE,  2, 32'h5A5A_5A5A);
        queue_request(REQ_INSERT, 127, 32'h3);
        queue_request(REQ_REMOVE, 1, 32'h0);
        queue_request(REQ_REMOVE, 2, 32'h0);
        queue_request(t_req_type'(3'd5), 0, 32'h0);
        queue_request(t_req_type'(3'd6), 64, 32'hAAAA_AAAA);
        queue_request(t_req_type'(3'd7), 127, 32'hFFFF_FFFF);
        queue_request(REQ_FILL,   0, 32'h1234_5678);
        queue_request(REQ_READ,   1, 32'h0);
        queue_request(REQ_REMOVE, 0, 32'h0);
        queue_request(REQ_REMOVE, 0, 32'h0);
        queue_request(REQ_REMOVE, 0, 32'h0);

        // Random part: open with a growth stretch so the full list is reached
        // early, then wander between moods.
        mood      = LIST_GROW;
        mood_left = 200;
        for (n = 0; n < RANDOM_REQS; n++) begin
            if (mood_left == 0) begin
                mood      = t_list_mood'($urandom_range(0, 2));
                mood_left = $urandom_range(40, 200);
            end
            mood_left--;
            queue_random_request(mood);
        end

        // Release reset at a falling edge, away from the rising edge.
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every request to go out and every result to return; valid
        // low with nothing pending means the last transaction is behind us.
        while (pending_reqs.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        // Give any stray result a chance to show.
        repeat (DRAIN_WAIT) @(negedge i_clk);

        if (err_count == 0 && expected_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
